/* sv/rpt_pkg.sv */
// Shared types, constants and character helpers of the pattern tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package rpt_pkg;

  // Token offsets wrap at this length; lengths saturate at it
  localparam int unsigned MaxPatternLen = 4096;
  localparam int unsigned PosW = $clog2(MaxPatternLen);
  localparam int unsigned LenW = PosW + 1;
  localparam int unsigned MaxNestDefault = 255;

  // Token kinds
  localparam logic [3:0] K_LIT     = 4'd0;
  localparam logic [3:0] K_GROUP   = 4'd1;
  localparam logic [3:0] K_COMMENT = 4'd2;
  localparam logic [3:0] K_CLASS   = 4'd3;
  localparam logic [3:0] K_QUANT   = 4'd4;
  localparam logic [3:0] K_ALT     = 4'd5;
  localparam logic [3:0] K_ANY     = 4'd6;
  localparam logic [3:0] K_START   = 4'd7;
  localparam logic [3:0] K_END     = 4'd8;
  localparam logic [3:0] K_ESC     = 4'd9;

  // Error codes
  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_UNTERM = 3'd1;
  localparam logic [2:0] E_ZERO   = 3'd2;
  localparam logic [2:0] E_ESC    = 3'd3;
  localparam logic [2:0] E_NEST   = 3'd4;

  // Characters with a meaning to the scanner
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_UPPER_Q = 8'h51;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LOWER_G = 8'h67;
  localparam logic [7:0] CH_LOWER_K = 8'h6B;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One result item
  typedef struct packed {
    logic [3:0]      kind;
    logic [PosW-1:0] start;
    logic [LenW-1:0] length;
    logic [2:0]      err;
    logic            lor;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage
`default_nettype wire

/* sv/rpt_scanner.sv */
// Scanner state and the single-pass step that turns one character into results.
`timescale 1ns / 1ps
`default_nettype none
module rpt_scanner #(
  parameter int unsigned MaxNest = rpt_pkg::MaxNestDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       character_i,
  input  wire logic             is_last_i,
  output logic [1:0]            push_n_o,
  output rpt_pkg::res_t [1:0]   push_data_o
);
  import rpt_pkg::*;

  localparam int unsigned DW = $clog2(MaxNest + 1);
  localparam logic [DW-1:0] NestMax = DW'(MaxNest);
  localparam logic [LenW-1:0] LenMax = LenW'(MaxPatternLen);

  typedef enum logic [16:0] {
    M_IDLE        = 17'h00001,
    M_DISCARD     = 17'h00002,
    M_HOLD_QUANT  = 17'h00004,
    M_BRACE       = 17'h00008,
    M_CLASS       = 17'h00010,
    M_ESC         = 17'h00020,
    M_ESC_EQ      = 17'h00040,
    M_ESC_NUM     = 17'h00080,
    M_ESC_K       = 17'h00100,
    M_ESC_NAME    = 17'h00200,
    M_ESC_G       = 17'h00400,
    M_ESC_GNUM    = 17'h00800,
    M_ESC_GNUM_BR = 17'h01000,
    M_ESC_X       = 17'h02000,
    M_ESC_X1      = 17'h04000,
    M_ESC_XBR     = 17'h08000,
    M_ESC_Q       = 17'h10000
  } mode_e;

  typedef struct packed {
    logic [DW-1:0] depth;
    logic [1:0]    phase;
    logic [1:0]    posix;
    logic          esc;
  } cls_t;

  // One character inside a bracket class, POSIX sub-classes nest
  function automatic cls_t class_step(input cls_t s, input logic [7:0] c,
                                      output logic closed, output logic [2:0] err);
    cls_t o;
    logic done;
    o = s;
    closed = 1'b0;
    err = E_NONE;
    done = 1'b0;
    if (c == CH_NUL) begin
      err = E_ZERO;
    end else if (s.esc) begin
      o.esc = 1'b0;
    end else begin
      if (o.phase == 2'd0) begin
        o.phase = 2'd1;
        if (c == CH_CARET) done = 1'b1;
      end
      if (!done && o.phase == 2'd1) begin
        o.phase = 2'd2;
        if (c == CH_RBRK) done = 1'b1;
      end
      if (!done && c == CH_BSL) begin
        o.esc = 1'b1;
        o.posix = 2'd0;
        done = 1'b1;
      end
      if (!done) begin
        if (o.posix == 2'd2) begin
          o.posix = 2'd0;
          if (is_letter(c)) begin
            done = 1'b1;
            if (o.depth >= NestMax) err = E_NEST;
            else o.depth = o.depth + 1'b1;
          end
        end else if (o.posix == 2'd1) begin
          o.posix = 2'd0;
          if (c == CH_COLON) begin
            o.posix = 2'd2;
            done = 1'b1;
          end
        end
      end
      if (!done && c == CH_LBRK) begin
        o.posix = 2'd1;
        done = 1'b1;
      end
      if (!done && c == CH_RBRK) begin
        o.depth = o.depth - 1'b1;
        if (o.depth == '0) closed = 1'b1;
      end
    end
    return o;
  endfunction

  mode_e           mode_q, mode_d;
  logic [DW-1:0]   bdepth_q, bdepth_d;
  cls_t            cls_q, cls_d;
  logic            obr_q, obr_d;
  logic            cact_q, cact_d;
  logic [1:0]      gpre_q, gpre_d;
  logic [1:0]      sub_q, sub_d;
  logic [PosW-1:0] begin_q, begin_d;
  logic [LenW-1:0] count_q, count_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      kind_q, kind_d;

  logic [7:0]      c;
  logic [1:0]      n;
  res_t [1:0]      res;
  logic            taken, clear_all, cl, holding;
  logic [2:0]      err, cerr;
  cls_t            cls_t_v;
  logic [7:0]      opener, closer;

  // Single-pass step of the scanner
  always_comb begin
    mode_d = mode_q; bdepth_d = bdepth_q; cls_d = cls_q; obr_d = obr_q;
    cact_d = cact_q; gpre_d = gpre_q; sub_d = sub_q; begin_d = begin_q;
    count_d = count_q; pos_d = pos_q; kind_d = kind_q;
    c = character_i;
    n = 2'd0;
    res = '0;
    taken = 1'b0;
    clear_all = 1'b0;
    err = E_NONE;
    cl = 1'b0;
    cerr = E_NONE;
    cls_t_v = cls_q;
    opener = obr_q ? CH_LBRACE : CH_LPAR;
    closer = obr_q ? CH_RBRACE : CH_RPAR;
    holding = 1'b0;

    if (accept_i) begin
      if (mode_q == M_DISCARD) begin
        clear_all = is_last_i;
      end else begin
        // A held token either grows by this character or is finished first
        if (mode_q == M_HOLD_QUANT || mode_q == M_ESC_NUM ||
            mode_q == M_ESC_K || mode_q == M_ESC_GNUM) begin
          if (mode_q == M_HOLD_QUANT && (c == CH_QMARK || c == CH_PLUS)) begin
            if (count_d < LenMax) count_d = count_d + 1'b1;
            res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
            mode_d = M_IDLE;
            taken = 1'b1;
          end else if ((mode_q == M_ESC_NUM || mode_q == M_ESC_GNUM) && is_digit(c)) begin
            if (count_d < LenMax) count_d = count_d + 1'b1;
            taken = 1'b1;
          end else if (mode_q == M_ESC_K && (c == CH_LT || c == CH_QUOTE)) begin
            if (count_d < LenMax) count_d = count_d + 1'b1;
            sub_d = (c == CH_QUOTE) ? 2'd1 : 2'd0;
            mode_d = M_ESC_NAME;
            taken = 1'b1;
          end else begin
            res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
            mode_d = M_IDLE;
          end
        end

        if (!taken) begin
          if (mode_d == M_IDLE) begin
            // Start of a new token
            begin_d = pos_q;
            count_d = LenW'(1);
            unique case (c)
              CH_LBRACE, CH_LPAR: begin
                kind_d = (c == CH_LBRACE) ? K_QUANT : K_GROUP;
                obr_d = (c == CH_LBRACE);
                bdepth_d = DW'(1);
                cls_d.esc = 1'b0;
                cact_d = 1'b0;
                gpre_d = (c == CH_LBRACE) ? 2'd0 : 2'd1;
                mode_d = M_BRACE;
              end
              CH_STAR, CH_PLUS, CH_QMARK: begin
                kind_d = K_QUANT;
                mode_d = M_HOLD_QUANT;
              end
              CH_LBRK: begin
                kind_d = K_CLASS;
                cls_d = '{DW'(1), 2'd0, 2'd0, 1'b0};
                mode_d = M_CLASS;
              end
              CH_BSL: begin
                kind_d = K_ESC;
                mode_d = M_ESC;
              end
              CH_BAR:    begin res[n[0]] = '{K_ALT, pos_q, LenW'(1), E_NONE, 1'b0}; n = n + 1'b1; end
              CH_DOT:    begin res[n[0]] = '{K_ANY, pos_q, LenW'(1), E_NONE, 1'b0}; n = n + 1'b1; end
              CH_CARET:  begin res[n[0]] = '{K_START, pos_q, LenW'(1), E_NONE, 1'b0}; n = n + 1'b1; end
              CH_DOLLAR: begin res[n[0]] = '{K_END, pos_q, LenW'(1), E_NONE, 1'b0}; n = n + 1'b1; end
              default:   begin res[n[0]] = '{K_LIT, pos_q, LenW'(1), E_NONE, 1'b0}; n = n + 1'b1; end
            endcase
          end else begin
            // Token in progress takes one more character
            if (count_d < LenMax) count_d = count_d + 1'b1;
            if (mode_d[16:5] != '0 && c == CH_NUL) begin
              err = E_ZERO;
            end else begin
              unique case (mode_d)
                M_BRACE: begin
                  if (gpre_d == 2'd1) begin
                    gpre_d = (c == CH_QMARK) ? 2'd2 : 2'd0;
                  end else if (gpre_d == 2'd2) begin
                    if (c == CH_HASH) kind_d = K_COMMENT;
                    gpre_d = 2'd0;
                  end
                  if (cact_d) begin
                    cls_t_v = class_step(cls_d, c, cl, cerr);
                    cls_d = cls_t_v;
                    if (cerr != E_NONE) err = cerr;
                    else if (cl) cact_d = 1'b0;
                  end else if (c == CH_NUL) begin
                    err = E_ZERO;
                  end else if (cls_d.esc) begin
                    cls_d.esc = 1'b0;
                  end else if (c == CH_LBRK) begin
                    cls_d = '{DW'(1), 2'd0, 2'd0, 1'b0};
                    cact_d = 1'b1;
                  end else if (c == CH_BSL) begin
                    cls_d.esc = 1'b1;
                  end else if (c == opener) begin
                    if (bdepth_d >= NestMax) err = E_NEST;
                    else bdepth_d = bdepth_d + 1'b1;
                  end else if (c == closer) begin
                    bdepth_d = bdepth_d - 1'b1;
                    if (bdepth_d == '0) begin
                      if (obr_d) begin
                        mode_d = M_HOLD_QUANT;
                      end else begin
                        res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                        mode_d = M_IDLE;
                      end
                    end
                  end
                end
                M_CLASS: begin
                  cls_t_v = class_step(cls_d, c, cl, cerr);
                  cls_d = cls_t_v;
                  if (cerr != E_NONE) begin
                    err = cerr;
                  end else if (cl) begin
                    res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                    mode_d = M_IDLE;
                  end
                end
                M_ESC: begin
                  if (c == CH_EQ) mode_d = M_ESC_EQ;
                  else if (c >= CH_ONE && c <= CH_NINE) mode_d = M_ESC_NUM;
                  else if (c == CH_LOWER_K) mode_d = M_ESC_K;
                  else if (c == CH_LOWER_G) begin
                    mode_d = M_ESC_G; sub_d = 2'd0; obr_d = 1'b0;
                  end else if (c == CH_LOWER_X) mode_d = M_ESC_X;
                  else if (c == CH_UPPER_Q) begin
                    mode_d = M_ESC_Q; cls_d.esc = 1'b0;
                  end else begin
                    res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                    mode_d = M_IDLE;
                  end
                end
                M_ESC_EQ: begin
                  res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                  mode_d = M_IDLE;
                end
                M_ESC_NAME: begin
                  if (c == (sub_d != 2'd0 ? CH_QUOTE : CH_GT)) begin
                    res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                    mode_d = M_IDLE;
                  end
                end
                M_ESC_G: begin
                  if (sub_d == 2'd0 && c == CH_LBRACE) begin
                    obr_d = 1'b1; sub_d = 2'd1;
                  end else if (sub_d < 2'd2 && c == CH_MINUS) begin
                    sub_d = 2'd2;
                  end else if (c < CH_ONE || c > CH_NINE) begin
                    err = E_ESC;
                  end else begin
                    mode_d = obr_d ? M_ESC_GNUM_BR : M_ESC_GNUM;
                  end
                end
                M_ESC_GNUM_BR: begin
                  if (!is_digit(c)) begin
                    if (c == CH_RBRACE) begin
                      res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                      mode_d = M_IDLE;
                    end else begin
                      err = E_ESC;
                    end
                  end
                end
                M_ESC_X: begin
                  if (c == CH_LBRACE) begin
                    mode_d = M_ESC_XBR; sub_d = 2'd0;
                  end else if (is_hex(c)) begin
                    mode_d = M_ESC_X1;
                  end else begin
                    err = E_ESC;
                  end
                end
                M_ESC_X1: begin
                  if (!is_hex(c)) begin
                    err = E_ESC;
                  end else begin
                    res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                    mode_d = M_IDLE;
                  end
                end
                M_ESC_XBR: begin
                  if (is_hex(c)) begin
                    sub_d = 2'd1;
                  end else if (c == CH_RBRACE && sub_d != 2'd0) begin
                    res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                    mode_d = M_IDLE;
                  end else begin
                    err = E_ESC;
                  end
                end
                M_ESC_Q: begin
                  if (cls_d.esc && c == CH_UPPER_E) begin
                    res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
                    mode_d = M_IDLE;
                  end else begin
                    cls_d.esc = (c == CH_BSL);
                  end
                end
                default: ;
              endcase
            end
          end
        end

        // Error: report the token so far, then drop characters
        if (err != E_NONE) begin
          res[n[0]] = '{kind_d, begin_d, count_d, err, 1'b0}; n = n + 1'b1;
          mode_d = M_DISCARD;
        end

        // End of pattern: flush any token still open
        if (is_last_i) begin
          holding = (mode_d == M_HOLD_QUANT || mode_d == M_ESC_NUM ||
                     mode_d == M_ESC_K || mode_d == M_ESC_GNUM);
          if (holding || mode_d == M_ESC_Q) begin
            res[n[0]] = '{kind_d, begin_d, count_d, E_NONE, 1'b0}; n = n + 1'b1;
          end else if (mode_d != M_IDLE && mode_d != M_DISCARD) begin
            res[n[0]] = '{kind_d, begin_d, count_d, E_UNTERM, 1'b0}; n = n + 1'b1;
          end
          clear_all = 1'b1;
        end
      end

      pos_d = pos_q + 1'b1;
      if (n == 2'd2) res[1].lor = 1'b1;
      else if (n == 2'd1) res[0].lor = 1'b1;
    end

    if (clear_all) begin
      mode_d = M_IDLE; bdepth_d = '0; cls_d = '0; obr_d = 1'b0; cact_d = 1'b0;
      gpre_d = 2'd0; sub_d = 2'd0; begin_d = '0; count_d = '0; pos_d = '0;
      kind_d = K_LIT;
    end
  end

  assign push_n_o = n;
  assign push_data_o = res;

  // Scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; bdepth_q <= '0; cls_q <= '0; obr_q <= 1'b0; cact_q <= 1'b0;
      gpre_q <= 2'd0; sub_q <= 2'd0; begin_q <= '0; count_q <= '0; pos_q <= '0;
      kind_q <= K_LIT;
    end else begin
      mode_q <= mode_d; bdepth_q <= bdepth_d; cls_q <= cls_d; obr_q <= obr_d;
      cact_q <= cact_d; gpre_q <= gpre_d; sub_q <= sub_d; begin_q <= begin_d;
      count_q <= count_d; pos_q <= pos_d; kind_q <= kind_d;
    end
  end

  // Nothing comes out of a pattern that is being dropped
  a_discard_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == M_DISCARD) |-> push_n_o == 2'd0)
    else $error("results while discarding");

  // An error always sends the scanner to discard unless the pattern ends
  a_err_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && err != E_NONE && !is_last_i) |=> mode_q == M_DISCARD)
    else $error("error did not enter discard");

  // The last character leaves the scanner idle at offset zero
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_last_i) |=> (mode_q == M_IDLE && pos_q == '0))
    else $error("state not cleared after last character");

endmodule
`default_nettype wire

/* sv/rpt_out_queue.sv */
// Four-entry result queue that takes up to two results and gives one per transfer.
`timescale 1ns / 1ps
`default_nettype none
module rpt_out_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         push_n_i,
  input  wire rpt_pkg::res_t [1:0] push_data_i,
  input  wire logic               pop_i,
  output logic                    room_o,
  output logic                    valid_o,
  output rpt_pkg::res_t           head_o
);
  import rpt_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;

  // Pointer and fill arithmetic
  always_comb begin
    wr_d = wr_q + push_n_i;
    rd_d = rd_q + {1'b0, pop_i};
    cnt_d = cnt_q + {1'b0, push_n_i} - {2'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push_data_i[0];
    if (push_n_i == 2'd2) mem_q[wr_q + 2'd1] <= push_data_i[1];
  end

  assign room_o  = (cnt_q <= 3'd2);
  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rd_q];

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> room_o) else $error("push without room");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && push_n_i == 2'd0) |=> cnt_q == $past(cnt_q) - 3'd1)
    else $error("pop did not drain one entry");

endmodule
`default_nettype wire

/* sv/regex_pattern_tokenizer.sv */
// Top level: the regular-expression pattern tokenizer.
// A result is written into the result queue when the character that ends it is transferred.
// Throughput: one character per cycle while in_stall_o is low; a character gives at most two results.
// in_stall_o rises while the result queue holds more than two results.
// Reset (rst_ni low, asynchronous) clears the scanner and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module regex_pattern_tokenizer #(
  parameter int unsigned MaxNest = rpt_pkg::MaxNestDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                character_i,
  input  wire logic                      is_last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [3:0]                     token_kind_o,
  output logic [rpt_pkg::PosW-1:0]       token_start_o,
  output logic [rpt_pkg::LenW-1:0]       token_length_o,
  output logic [2:0]                     error_code_o,
  output logic                           last_of_run_o
);
  import rpt_pkg::*;

  logic       room, accept, pop;
  logic [1:0] push_n;
  res_t [1:0] push_data;
  res_t       head;

  assign in_stall_o = !room;
  assign accept = in_valid_i && room;
  assign pop = out_valid_o && !out_stall_i;

  rpt_scanner #(.MaxNest(MaxNest)) u_scanner (
    .clk_i, .rst_ni,
    .accept_i    (accept),
    .character_i,
    .is_last_i,
    .push_n_o    (push_n),
    .push_data_o (push_data)
  );

  rpt_out_queue u_queue (
    .clk_i, .rst_ni,
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .pop_i       (pop),
    .room_o      (room),
    .valid_o     (out_valid_o),
    .head_o      (head)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign error_code_o   = head.err;
  assign last_of_run_o  = head.lor;

endmodule
`default_nettype wire
